FILE: rtl/abcr_pkg.sv
package abcr_pkg;

    // Sample width default and fixed field widths
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int BD_W             = 5;
    localparam int HP_W             = 7;
    localparam int MIX_W            = 16;
    localparam int MIX_FRAC         = MIX_W - 1;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;

    // Unity wet share in Q1.15
    localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(1) << MIX_FRAC;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_BIT_DEPTH   = 2'd0;
    localparam logic [1:0] REG_HOLD_PERIOD = 2'd1;
    localparam logic [1:0] REG_WET_MIX     = 2'd2;

    // Reset values of the registers
    localparam logic [BD_W-1:0]  BIT_DEPTH_RST   = 5'd8;
    localparam logic [HP_W-1:0]  HOLD_PERIOD_RST = 7'd2;
    localparam logic [MIX_W-1:0] WET_MIX_RST     = MIX_ONE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } abcr_state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } abcr_ctrl_t;

endpackage

FILE: rtl/abcr_in_if.sv
interface abcr_in_if #(
    parameter int SAMPLE_WIDTH = abcr_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

FILE: rtl/abcr_out_if.sv
interface abcr_out_if #(
    parameter int SAMPLE_WIDTH = abcr_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

FILE: rtl/abcr_serial_mac.sv
module abcr_serial_mac #(
    parameter int SAMPLE_WIDTH = abcr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                             clk,
    input  abcr_pkg::abcr_ctrl_t                             ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]                   held,
    input  logic signed [SAMPLE_WIDTH-1:0]                   dry,
    input  logic        [abcr_pkg::BD_W-1:0]                 bit_depth,
    input  logic        [abcr_pkg::MIX_W-1:0]                mix,
    output logic signed [SAMPLE_WIDTH+abcr_pkg::MIX_W-1:0]   acc
);
    import abcr_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int ACC_W = W + MIX_W;
    localparam int IDX_W = $clog2(W);

    logic [W-1:0]            u;
    logic [BD_W-1:0]         bd_eff;
    logic                    pass;
    logic [BD_W-1:0]         sh_hi;
    logic [W-1:0]            u_hi;
    logic [W-1:0]            u_lo_sh;
    logic [W-1:0]            q;
    logic                    wbit;
    logic                    xbit;
    logic signed [ACC_W-1:0] mix_ext;

    logic [W-1:0]            rot_reg,  rot_next;
    logic [IDX_W-1:0]        bidx_reg, bidx_next;
    logic [W-1:0]            xu_reg,   xu_next;
    logic [MIX_W-1:0]        mix_reg,  mix_next;
    logic signed [ACC_W-1:0] acc_reg,  acc_next;

    // Offset-binary held sample and effective depth
    always_comb
    begin
        u       = {~held[W-1], held[W-2:0]};
        bd_eff  = (bit_depth == '0) ? BD_W'(1) : bit_depth;
        pass    = int'(bd_eff) >= W;
        sh_hi   = pass ? '0 : (BD_W'(W) - bd_eff);
        u_hi    = u >> sh_hi;
        u_lo_sh = u << bd_eff;
        // floor(u*(2^b-1)/2^W): top b bits, less one when the low part falls short
        q       = u_hi - W'(u_lo_sh < u);
    end

    // Requantized value is q repeated every b bits, read MSB first from a rotator
    assign wbit    = rot_reg[bidx_reg];
    assign xbit    = xu_reg[W-1];
    assign mix_ext = signed'({{(ACC_W-MIX_W){1'b0}}, mix_reg});

    always_comb
    begin
        rot_next  = rot_reg;
        bidx_next = bidx_reg;
        xu_next   = xu_reg;
        mix_next  = mix_reg;
        acc_next  = acc_reg;
        if (ctrl.load)
        begin
            rot_next  = pass ? u : q;
            bidx_next = pass ? IDX_W'(W - 1) : IDX_W'(bd_eff - BD_W'(1));
            xu_next   = {~dry[W-1], dry[W-2:0]};
            mix_next  = mix;
            acc_next  = '0;
        end
        else if (ctrl.shift)
        begin
            rot_next = {rot_reg[W-2:0], wbit};
            xu_next  = {xu_reg[W-2:0], 1'b0};
            // Horner step on digit (wet bit - dry bit) in {-1, 0, 1}
            if (wbit && !xbit)
                acc_next = (acc_reg <<< 1) + mix_ext;
            else if (!wbit && xbit)
                acc_next = (acc_reg <<< 1) - mix_ext;
            else
                acc_next = acc_reg <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg  <= rot_next;
        bidx_reg <= bidx_next;
        xu_reg   <= xu_next;
        mix_reg  <= mix_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/audio_bitcrusher_unit.sv
// A new sample is taken only in the idle state, after the bit-serial
//   multiply-accumulate, which walks one bit of crushed and dry sample per cycle,
//   has finished and its result has gone to the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, asynchronous): registers return to bit_depth 8,
//   hold_period 2, wet_mix 32768; hold counter and held sample clear to zero.
module audio_bitcrusher_unit #(
    parameter int SAMPLE_WIDTH = abcr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abcr_pkg::ADDR_W-1:0]   paddr,
    input  logic [abcr_pkg::DATA_W-1:0]   pwdata,
    output logic [abcr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // sample streams
    abcr_in_if.sink                       in_ch,
    abcr_out_if.source                    out_ch
);
    import abcr_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int ACC_W = W + MIX_W;
    localparam int CNT_W = $clog2(W);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BD_W-1:0]  bit_depth_reg,   bit_depth_next;
    logic [HP_W-1:0]  hold_period_reg, hold_period_next;
    logic [MIX_W-1:0] wet_mix_reg,     wet_mix_next;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        bit_depth_next   = bit_depth_reg;
        hold_period_next = hold_period_reg;
        wet_mix_next     = wet_mix_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BIT_DEPTH:   bit_depth_next   = pwdata[BD_W-1:0];
                REG_HOLD_PERIOD: hold_period_next = pwdata[HP_W-1:0];
                REG_WET_MIX:     wet_mix_next     = pwdata[MIX_W-1:0];
                default:         ; // drop writes outside the register map
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BIT_DEPTH:   prdata = DATA_W'(bit_depth_reg);
            REG_HOLD_PERIOD: prdata = DATA_W'(hold_period_reg);
            REG_WET_MIX:     prdata = DATA_W'(wet_mix_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg   <= BIT_DEPTH_RST;
            hold_period_reg <= HOLD_PERIOD_RST;
            wet_mix_reg     <= WET_MIX_RST;
        end
        else
        begin
            bit_depth_reg   <= bit_depth_next;
            hold_period_reg <= hold_period_next;
            wet_mix_reg     <= wet_mix_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: take a sample, load the serial datapath, walk W bits,
    // then hand the result to the output register.
    // ------------------------------------------------------------------
    abcr_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg,   cnt_next;
    logic [HP_W-1:0]         hold_cnt_reg, hold_cnt_next;
    logic signed [W-1:0]     held_reg,  held_next;
    logic signed [W-1:0]     dry_reg,   dry_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [W-1:0]     out_data_reg,  out_data_next;

    abcr_ctrl_t              ctrl;
    logic                    in_xfer;
    logic                    out_free;
    logic [HP_W-1:0]         period_eff;
    logic [HP_W-1:0]         hold_inc;
    logic [MIX_W-1:0]        mix_eff;
    logic signed [ACC_W-1:0] acc;
    logic signed [W:0]       blend;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // A zero period latches every sample; a wet share above unity acts as unity
    assign period_eff = (hold_period_reg == '0) ? HP_W'(1) : hold_period_reg;
    assign hold_inc   = hold_cnt_reg + HP_W'(1);
    assign mix_eff    = (wet_mix_reg > MIX_ONE) ? MIX_ONE : wet_mix_reg;

    // y = dry + floor((wet - dry) * mix / 2^15); stays between dry and wet
    assign blend = {dry_reg[W-1], dry_reg} + acc[ACC_W-1:MIX_FRAC];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hold_cnt_next  = hold_cnt_reg;
        held_next      = held_reg;
        dry_next       = dry_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        ctrl.load      = 1'b0;
        ctrl.shift     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    dry_next = in_ch.sample_in;
                    // advance the hold counter; latch a new held sample on period
                    if (hold_inc >= period_eff)
                    begin
                        held_next     = in_ch.sample_in;
                        hold_cnt_next = '0;
                    end
                    else
                    begin
                        hold_cnt_next = hold_inc;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                cnt_next   = CNT_W'(W - 1);
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                ctrl.shift = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = blend[W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hold_cnt_reg  <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hold_cnt_reg  <= hold_cnt_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dry_reg      <= dry_next;
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

    // ------------------------------------------------------------------
    // Bit-serial crush and blend datapath
    // ------------------------------------------------------------------
    abcr_serial_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk       (clk),
        .ctrl      (ctrl),
        .held      (held_reg),
        .dry       (dry_reg),
        .bit_depth (bit_depth_reg),
        .mix       (mix_eff),
        .acc       (acc)
    );

endmodule
